@@ design/qds_pkg.sv @@
// Package for the 2x2 quarter downsampler.
// Holds shared types, format and register codes, and arithmetic constants.
// No dependencies.
package qds_pkg;

    // Pixel format codes (format 3 is handled as RGBA)
    localparam logic [1:0] FMT_GRAY = 2'd0;
    localparam logic [1:0] FMT_RGB  = 2'd1;
    localparam logic [1:0] FMT_RGBA = 2'd2;

    // Configuration register indexes
    localparam logic REG_PIXEL_FORMAT = 1'b0;
    localparam logic REG_HARD_TRANSP  = 1'b1;

    localparam int LANE_W   = 8;
    localparam int SUM_W    = 10;
    localparam int RECIP3_W = 10;
    localparam int PROD_W   = SUM_W + RECIP3_W;
    localparam int RECIP3_SHIFT = 11;

    localparam logic [SUM_W-1:0]    ALPHA_FULL_SUM = SUM_W'(255 * 4);
    localparam logic [LANE_W-1:0]   ALPHA_OPAQUE   = LANE_W'(255);
    // floor(x / 3) == (x * 683) >> 11 for every x up to 3 * 255
    localparam logic [RECIP3_W-1:0] RECIP3         = RECIP3_W'(683);

    typedef logic [SUM_W-1:0] sum_t;

    typedef enum logic [1:0] {
        DIV_BY1 = 2'd0,
        DIV_BY2 = 2'd1,
        DIV_BY3 = 2'd2,
        DIV_BY4 = 2'd3
    } div_sel_t;

    // First stage: raw lane sums and sums over pixels with nonzero alpha
    typedef struct packed {
        sum_t [3:0] lane_sum;
        sum_t [2:0] mask_sum;
        logic [2:0] opaque_cnt;
    } s1_t;

    // Second stage: chosen colour sums, divisor and final alpha
    typedef struct packed {
        sum_t [2:0]        color_sum;
        div_sel_t          div_sel;
        logic [LANE_W-1:0] alpha;
        logic [1:0]        fmt;
    } s2_t;

endpackage

@@ design/quarter_downsample_2x2_unit.sv @@
// Top level of the 2x2 quarter downsampler: three-stage pipeline and control.
// Depends on qds_pkg, qds_sum_stage, qds_select_stage, qds_div_stage.
//
// Usage:
//   Input channel (in_valid / in_stall) carries the four pixels of one 2x2
//   block; output channel (out_valid / out_stall) carries the averaged pixel.
//   A transfer happens at a rising edge with valid high and stall low.
//   Configuration: pulse cfg_we with cfg_index and cfg_wdata; index 0 is the
//   pixel format, index 1 the hard transparency enable. Write only while the
//   pipeline is empty.
//   Pipeline: each block passes through three registers (sums, select,
//   divide/pack) before its result shows on out_valid.
//   Throughput: one block per cycle, set by the three pipeline registers
//   each of which advances every cycle the stage after it can take data.
//   Stall: out_stall freezes a valid output register; stages behind it keep
//   filling bubbles, and in_stall rises only once every stage is full.
//   Reset: all valid bits clear, format returns to RGBA and hard
//   transparency to off.
module quarter_downsample_2x2_unit
    import qds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] pixel_top_left,
    input  logic [31:0] pixel_top_right,
    input  logic [31:0] pixel_bottom_left,
    input  logic [31:0] pixel_bottom_right,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pixel_out
);

    logic [1:0] fmt_reg;
    logic       hard_transp_reg;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic ready1;
    logic ready2;
    logic ready3;

    logic [3:0][31:0] px;
    s1_t              s1;
    s2_t              s2;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg         <= FMT_RGBA;
            hard_transp_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PIXEL_FORMAT: fmt_reg         <= cfg_wdata;
                REG_HARD_TRANSP:  hard_transp_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances
    assign ready3   = !v3_reg || !out_stall;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_stall = !ready1;

    // Valid bits travel with the data; hold a stage while the next one is full and cannot advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign px = {pixel_bottom_right, pixel_bottom_left, pixel_top_right, pixel_top_left};

    qds_sum_stage u_sum (
        .clk    (clk),
        .en     (ready1 && in_valid),
        .px     (px),
        .s1_reg (s1)
    );

    qds_select_stage u_select (
        .clk         (clk),
        .en          (ready2 && v1_reg),
        .s1          (s1),
        .fmt         (fmt_reg),
        .hard_transp (hard_transp_reg),
        .s2_reg      (s2)
    );

    qds_div_stage u_div (
        .clk       (clk),
        .en        (ready3 && v2_reg),
        .s2        (s2),
        .pixel_reg (pixel_out)
    );

    assign out_valid = v3_reg;

endmodule

@@ design/qds_sum_stage.sv @@
// First pipeline stage of the quarter downsampler: per-lane sums of the block.
// Depends on qds_pkg.
module qds_sum_stage
    import qds_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [3:0][31:0] px,
    output s1_t              s1_reg
);

    s1_t        s1_next;
    logic [3:0] nz_alpha;

    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            nz_alpha[p] = (px[p][31:24] != '0);
        end
        for (int k = 0; k < 4; k++)
        begin
            s1_next.lane_sum[k] = SUM_W'(px[0][8*k +: 8]) + SUM_W'(px[1][8*k +: 8])
                                + SUM_W'(px[2][8*k +: 8]) + SUM_W'(px[3][8*k +: 8]);
        end
        // colour sums over pixels that are not fully transparent
        for (int k = 0; k < 3; k++)
        begin
            s1_next.mask_sum[k] = (nz_alpha[0] ? SUM_W'(px[0][8*k +: 8]) : '0)
                                + (nz_alpha[1] ? SUM_W'(px[1][8*k +: 8]) : '0)
                                + (nz_alpha[2] ? SUM_W'(px[2][8*k +: 8]) : '0)
                                + (nz_alpha[3] ? SUM_W'(px[3][8*k +: 8]) : '0);
        end
        s1_next.opaque_cnt = 3'(nz_alpha[0]) + 3'(nz_alpha[1])
                           + 3'(nz_alpha[2]) + 3'(nz_alpha[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

endmodule

@@ design/qds_select_stage.sv @@
// Second pipeline stage: picks plain or alpha-aware averaging and the alpha.
// Depends on qds_pkg.
module qds_select_stage
    import qds_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  s1_t        s1,
    input  logic [1:0] fmt,
    input  logic       hard_transp,
    output s2_t        s2_reg
);

    s2_t  s2_next;
    sum_t asum;
    logic is_rgba;
    logic mixed;

    always_comb
    begin
        asum    = s1.lane_sum[3];
        is_rgba = (fmt != FMT_GRAY) && (fmt != FMT_RGB);
        mixed   = is_rgba && hard_transp && (asum != '0) && (asum != ALPHA_FULL_SUM);

        s2_next.fmt = fmt;
        if (mixed)
        begin
            s2_next.color_sum = s1.mask_sum;
            s2_next.alpha     = asum[9:2];
            unique case (s1.opaque_cnt)
                3'd1:    s2_next.div_sel = DIV_BY1;
                3'd2:    s2_next.div_sel = DIV_BY2;
                3'd3:    s2_next.div_sel = DIV_BY3;
                default: s2_next.div_sel = DIV_BY4;
            endcase
        end
        else
        begin
            s2_next.color_sum = s1.lane_sum[2:0];
            s2_next.div_sel   = DIV_BY4;
            if (hard_transp)
            begin
                s2_next.alpha = (asum == '0) ? '0 : ALPHA_OPAQUE;
            end
            else
            begin
                s2_next.alpha = asum[9:2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
        end
    end

endmodule

@@ design/qds_div_stage.sv @@
// Third pipeline stage: divides the colour sums and packs the output pixel.
// Depends on qds_pkg.
module qds_div_stage
    import qds_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  s2_t         s2,
    output logic [31:0] pixel_reg
);

    logic [2:0][LANE_W-1:0] quot;
    logic [2:0][PROD_W-1:0] prod3;
    logic [31:0]            pixel_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod3[k] = PROD_W'(s2.color_sum[k]) * PROD_W'(RECIP3);
            case (s2.div_sel)
                DIV_BY1: quot[k] = s2.color_sum[k][7:0];
                DIV_BY2: quot[k] = s2.color_sum[k][8:1];
                DIV_BY3: quot[k] = prod3[k][RECIP3_SHIFT +: LANE_W];
                default: quot[k] = s2.color_sum[k][9:2];
            endcase
        end
        case (s2.fmt)
            FMT_GRAY: pixel_next = {24'd0, quot[0]};
            FMT_RGB:  pixel_next = {8'd0, quot[2], quot[1], quot[0]};
            default:  pixel_next = {s2.alpha, quot[2], quot[1], quot[0]};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pixel_reg <= pixel_next;
        end
    end

endmodule

@@ design/qds_checker.sv @@
// Port-level checker for the quarter downsampler, bound to the top level.
// Depends on qds_pkg and quarter_downsample_2x2_unit.
module qds_checker
    import qds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] pixel_out
);

    logic [1:0] fmt_reg;
    logic [1:0] inflight_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    // Track the format and the number of blocks inside the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg      <= FMT_RGBA;
            inflight_reg <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_PIXEL_FORMAT))
            begin
                fmt_reg <= cfg_wdata;
            end
            if (in_xfer && !out_xfer)
            begin
                inflight_reg <= inflight_reg + 2'd1;
            end
            else if (!in_xfer && out_xfer)
            begin
                inflight_reg <= inflight_reg - 2'd1;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_out))
        else $error("output changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 2'd0)
        else $error("result with no block in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !out_xfer |-> inflight_reg != 2'd3)
        else $error("more than three blocks in flight");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && inflight_reg == 2'd0 && !cfg_we |-> ##3 out_valid)
        else $error("empty pipeline did not deliver in three cycles");

    a_gray_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fmt_reg == FMT_GRAY |-> pixel_out[31:8] == 24'd0)
        else $error("unused lanes not zero in single-channel format");

endmodule

bind quarter_downsample_2x2_unit qds_checker u_qds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_out (pixel_out)
);
